/* src/ssvf_pkg.sv */
// package for the seven segment value formatter
// shared codes, register addresses and transaction bundle types; no dependencies
package ssvf_pkg;

  typedef enum logic [1:0] {
    REQ_INIT = 2'd0,
    REQ_TEMP = 2'd1,
    REQ_HUM  = 2'd2
  } req_e;

  // configuration register indexes
  localparam logic [1:0] CFG_DECODE = 2'd0;
  localparam logic [1:0] CFG_INTENS = 2'd1;
  localparam logic [1:0] CFG_SCAN   = 2'd2;

  // driver register addresses
  localparam logic [3:0] ADDR_DIGIT0   = 4'h1;
  localparam logic [3:0] ADDR_DECODE   = 4'h9;
  localparam logic [3:0] ADDR_INTENS   = 4'hA;
  localparam logic [3:0] ADDR_SCAN     = 4'hB;
  localparam logic [3:0] ADDR_SHUTDOWN = 4'hC;
  localparam logic [3:0] ADDR_TEST     = 4'hF;

  // code-b digit codes
  localparam logic [3:0] CODE_MINUS = 4'hA;
  localparam logic [3:0] CODE_BLANK = 4'hF;
  localparam logic [7:0] DP_FLAG    = 8'h80;
  localparam logic [7:0] SHUTDOWN_OFF = 8'h01;
  localparam logic [7:0] TEST_OFF     = 8'h00;

  localparam logic signed [15:0] TEMP_LIMIT = 16'sd9999;

  // reciprocal constants for division by 100 and by 10
  localparam logic [12:0] RECIP_100 = 13'd5243;  // >> 19
  localparam logic [7:0]  RECIP_10  = 8'd205;    // >> 11

  localparam int unsigned MAX_WR = 5;

  typedef struct packed {
    logic [7:0] decode_mode;
    logic [3:0] intensity;
    logic [2:0] scan_limit;
  } cfg_t;

  // converted operands after the arithmetic stages
  typedef struct packed {
    req_e       req;
    logic       neg;
    logic [6:0] q1;    // temperature magnitude / 100
    logic [6:0] r1;    // temperature magnitude % 100
    logic [1:0] hhi;   // humidity hundreds
    logic [6:0] hrem;  // humidity % 100
  } conv_t;

  // burst of register writes caused by one request
  typedef struct packed {
    logic [MAX_WR-1:0][3:0] addr;
    logic [MAX_WR-1:0][7:0] data;
    logic [2:0]             cnt;
  } bndl_t;

endpackage

/* src/ssvf_conv.sv */
// three-stage arithmetic front end: saturation and magnitude, divide by 100, remainder
// depends on ssvf_pkg
module ssvf_conv (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           req_type_i,
  input  logic signed [15:0]   temperature_i,
  input  logic [7:0]           humidity_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ssvf_pkg::conv_t      out_o
);
  import ssvf_pkg::*;

  typedef struct packed {
    req_e        req;
    logic        neg;
    logic [13:0] mag;
    logic [1:0]  hhi;
    logic [6:0]  hrem;
  } s1_t;

  typedef struct packed {
    req_e        req;
    logic        neg;
    logic [13:0] mag;
    logic [6:0]  q1;
    logic [1:0]  hhi;
    logic [6:0]  hrem;
  } s2_t;

  logic  v1_q, v2_q, v3_q;
  logic  rdy1, rdy2, rdy3;
  s1_t   s1_d, s1_q;
  s2_t   s2_d, s2_q;
  conv_t s3_d, s3_q;

  logic signed [15:0] sat;
  logic [15:0]        mag16;
  logic [26:0]        prod;
  logic [13:0]        rem14;
  logic               req_ok;

  assign rdy3 = !v3_q || out_ready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // stage 1: clamp, magnitude, humidity hundreds by compare
  assign req_ok = (req_type_i == REQ_INIT) || (req_type_i == REQ_TEMP) ||
                  (req_type_i == REQ_HUM);

  always_comb begin
    if (temperature_i > TEMP_LIMIT) begin
      sat = TEMP_LIMIT;
    end else if (temperature_i < -TEMP_LIMIT) begin
      sat = -TEMP_LIMIT;
    end else begin
      sat = temperature_i;
    end
    mag16 = sat[15] ? 16'(-sat) : 16'(sat);
    s1_d.req = req_e'(req_type_i);
    s1_d.neg = sat[15];
    s1_d.mag = mag16[13:0];
    if (humidity_i >= 8'd200) begin
      s1_d.hhi  = 2'd2;
      s1_d.hrem = 7'(humidity_i - 8'd200);
    end else if (humidity_i >= 8'd100) begin
      s1_d.hhi  = 2'd1;
      s1_d.hrem = 7'(humidity_i - 8'd100);
    end else begin
      s1_d.hhi  = 2'd0;
      s1_d.hrem = humidity_i[6:0];
    end
  end

  // stage 2: quotient by 100 through reciprocal multiply
  assign prod = 27'(s1_q.mag) * 27'(RECIP_100);

  always_comb begin
    s2_d.req  = s1_q.req;
    s2_d.neg  = s1_q.neg;
    s2_d.mag  = s1_q.mag;
    s2_d.q1   = prod[25:19];
    s2_d.hhi  = s1_q.hhi;
    s2_d.hrem = s1_q.hrem;
  end

  // stage 3: remainder
  assign rem14 = s2_q.mag - 14'(s2_q.q1) * 14'd100;

  always_comb begin
    s3_d.req  = s2_q.req;
    s3_d.neg  = s2_q.neg;
    s3_d.q1   = s2_q.q1;
    s3_d.r1   = rem14[6:0];
    s3_d.hhi  = s2_q.hhi;
    s3_d.hrem = s2_q.hrem;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i && req_ok;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) s1_q <= s1_d;
    if (rdy2) s2_q <= s2_d;
    if (rdy3) s3_q <= s3_d;
  end

  assign out_valid_o = v3_q;
  assign out_o       = s3_q;

endmodule

/* src/ssvf_fmt.sv */
// digit split and code-b burst builder, one register stage
// depends on ssvf_pkg
module ssvf_fmt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ssvf_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ssvf_pkg::conv_t   in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ssvf_pkg::bndl_t   out_o
);
  import ssvf_pkg::*;

  logic        v_q;
  bndl_t       b_d, b_q;
  logic [14:0] pq, pr, ph;
  logic [3:0]  q_t, q_u, r_t, r_u, h_t, h_u;
  logic [6:0]  q_ud, r_ud, h_ud;
  logic [3:0]  d0, d1, hi, mid;

  // tens by reciprocal multiply, units by subtract
  assign pq = 15'(in_i.q1) * 15'(RECIP_10);
  assign pr = 15'(in_i.r1) * 15'(RECIP_10);
  assign ph = 15'(in_i.hrem) * 15'(RECIP_10);
  assign q_t = pq[14:11];
  assign r_t = pr[14:11];
  assign h_t = ph[14:11];
  assign q_ud = in_i.q1 - 7'(q_t) * 7'd10;
  assign r_ud = in_i.r1 - 7'(r_t) * 7'd10;
  assign h_ud = in_i.hrem - 7'(h_t) * 7'd10;
  assign q_u = q_ud[3:0];
  assign r_u = r_ud[3:0];
  assign h_u = h_ud[3:0];

  always_comb begin
    // sign moves into a zero tens digit
    if (q_t == 4'd0) begin
      d0 = CODE_BLANK;
      d1 = in_i.neg ? CODE_MINUS : CODE_BLANK;
    end else begin
      d0 = in_i.neg ? CODE_MINUS : CODE_BLANK;
      d1 = q_t;
    end
    // leading zero blanking
    hi  = (in_i.hhi == 2'd0) ? CODE_BLANK : 4'(in_i.hhi);
    mid = ((in_i.hhi == 2'd0) && (h_t == 4'd0)) ? CODE_BLANK : h_t;

    b_d = '0;
    case (in_i.req)
      REQ_INIT: begin
        b_d.addr[0] = ADDR_SHUTDOWN; b_d.data[0] = SHUTDOWN_OFF;
        b_d.addr[1] = ADDR_TEST;     b_d.data[1] = TEST_OFF;
        b_d.addr[2] = ADDR_DECODE;   b_d.data[2] = cfg_i.decode_mode;
        b_d.addr[3] = ADDR_INTENS;   b_d.data[3] = 8'(cfg_i.intensity);
        b_d.addr[4] = ADDR_SCAN;     b_d.data[4] = 8'(cfg_i.scan_limit);
        b_d.cnt     = 3'd5;
      end
      REQ_TEMP: begin
        b_d.addr[0] = ADDR_DIGIT0;        b_d.data[0] = 8'(d0);
        b_d.addr[1] = ADDR_DIGIT0 + 4'd1; b_d.data[1] = 8'(d1);
        b_d.addr[2] = ADDR_DIGIT0 + 4'd2; b_d.data[2] = 8'(q_u) | DP_FLAG;
        b_d.addr[3] = ADDR_DIGIT0 + 4'd3; b_d.data[3] = 8'(r_t);
        b_d.addr[4] = ADDR_DIGIT0 + 4'd4; b_d.data[4] = 8'(r_u);
        b_d.cnt     = 3'd5;
      end
      REQ_HUM: begin
        b_d.addr[0] = ADDR_DIGIT0 + 4'd5; b_d.data[0] = 8'(hi);
        b_d.addr[1] = ADDR_DIGIT0 + 4'd6; b_d.data[1] = 8'(mid);
        b_d.addr[2] = ADDR_DIGIT0 + 4'd7; b_d.data[2] = 8'(h_u);
        b_d.cnt     = 3'd3;
      end
      default: begin
        b_d.cnt = 3'd3;
      end
    endcase
  end

  assign in_ready_o = !v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) b_q <= b_d;
  end

  assign out_valid_o = v_q;
  assign out_o       = b_q;

endmodule

/* src/ssvf_ser.sv */
// serializer that plays a burst out as one register write transaction per cycle while out_stall_i is low
// depends on ssvf_pkg
module ssvf_ser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ssvf_pkg::bndl_t   in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [3:0]        reg_addr_o,
  output logic [7:0]        reg_data_o,
  output logic              last_o
);
  import ssvf_pkg::*;

  logic       v_q, v_d;
  bndl_t      b_q;
  logic [2:0] idx_q, idx_d;
  logic       beat, fin;

  assign fin  = (idx_q == b_q.cnt - 3'd1);
  assign beat = v_q && !out_stall_i;
  assign in_ready_o = !v_q || (beat && fin);

  always_comb begin
    v_d   = v_q;
    idx_d = idx_q;
    if (in_ready_o) begin
      v_d   = in_valid_i;
      idx_d = 3'd0;
    end else if (beat) begin
      idx_d = idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= 1'b0;
      idx_q <= 3'd0;
    end else begin
      v_q   <= v_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) b_q <= in_i;
  end

  assign out_valid_o = v_q;
  assign reg_addr_o  = b_q.addr[idx_q];
  assign reg_data_o  = b_q.data[idx_q];
  assign last_o      = fin;

`ifndef SYNTH
  a_cnt_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q |-> (b_q.cnt == 3'd3 || b_q.cnt == 3'd5))
    else $error("burst length not 3 or 5");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q |-> (idx_q < b_q.cnt))
    else $error("write index beyond burst");

  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat && !fin) |=> (v_q && idx_q == $past(idx_q) + 3'd1))
    else $error("burst did not advance by one write");

  a_idx_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q && out_stall_i) |=> (idx_q == $past(idx_q)))
    else $error("write index moved under stall");
`endif

endmodule

/* src/seven_segment_value_formatter_unit.sv */
// path: conv stages 1 to 3, fmt stage 4, then the serializer burst register drives the first write
// one write per cycle unless stalled; 5 writes per burst (init, temperature), 3 (humidity)
// the serializer's one-write-per-cycle output port sets the sustained request rate
// input side takes a request every cycle while the 4 pipeline stages have room
// reset: asynchronous active low, clears all valid bits and loads the config defaults
// (decode 0xff, intensity 0xf, scan limit 7); request code 3 is taken and dropped
module seven_segment_value_formatter_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [15:0] temperature_i,
  input  logic [7:0]         humidity_i,
  // register write channel toward the display driver
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [3:0]         reg_addr_o,
  output logic [7:0]         reg_data_o,
  output logic               last_o,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [7:0]         cfg_wdata_i
);
  import ssvf_pkg::*;

  cfg_t  cfg_q;
  logic  conv_rdy, conv_v;
  conv_t conv;
  logic  fmt_rdy, fmt_v;
  bndl_t bndl;
  logic  ser_rdy;

  // config registers, always writable; index 3 is ignored
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decode_mode <= 8'hFF;
      cfg_q.intensity   <= 4'hF;
      cfg_q.scan_limit  <= 3'd7;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_DECODE: cfg_q.decode_mode <= cfg_wdata_i;
        CFG_INTENS: cfg_q.intensity   <= cfg_wdata_i[3:0];
        CFG_SCAN:   cfg_q.scan_limit  <= cfg_wdata_i[2:0];
        default: begin
        end
      endcase
    end
  end

  // stages 1 to 3: clamp and magnitude, divide by 100, remainder
  ssvf_conv u_conv (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (conv_rdy),
    .req_type_i    (req_type_i),
    .temperature_i (temperature_i),
    .humidity_i    (humidity_i),
    .out_valid_o   (conv_v),
    .out_ready_i   (fmt_rdy),
    .out_o         (conv)
  );

  assign in_stall_o = !conv_rdy;

  // stage 4: digits, blanking and the write burst
  ssvf_fmt u_fmt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (conv_v),
    .in_ready_o  (fmt_rdy),
    .in_i        (conv),
    .out_valid_o (fmt_v),
    .out_ready_i (ser_rdy),
    .out_o       (bndl)
  );

  // burst register plays one write per cycle unless stalled, takes the next burst on the last one
  ssvf_ser u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fmt_v),
    .in_ready_o  (ser_rdy),
    .in_i        (bndl),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .reg_addr_o  (reg_addr_o),
    .reg_data_o  (reg_data_o),
    .last_o      (last_o)
  );

`ifndef SYNTH
  a_cfg_mask_int: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_index_i == CFG_INTENS) |=> (cfg_q.intensity == $past(cfg_wdata_i[3:0])))
    else $error("intensity write lost");

  a_last_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> (reg_addr_o == ADDR_SCAN ||
      reg_addr_o == ADDR_DIGIT0 + 4'd4 || reg_addr_o == ADDR_DIGIT0 + 4'd7))
    else $error("burst ends on an unexpected register");

  a_dp_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && reg_addr_o == ADDR_DIGIT0 + 4'd2) |-> reg_data_o[7])
    else $error("decimal point missing on units digit");
`endif

endmodule

/* dv/testbench.sv */
// testbench for seven_segment_value_formatter_unit: random and directed requests with a
// self-checking scoreboard that predicts every display register write transaction
// depends on src/ssvf_pkg.sv and src/seven_segment_value_formatter_unit.sv
`timescale 1ns / 100ps

module testbench;
  import ssvf_pkg::*;

  // request code that the block takes and drops
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // config index with no register behind it
  localparam logic [1:0] CFG_NONE = 2'd3;
  // cycles allowed for a dropped request to drain before a config write
  localparam int unsigned DRAIN_CYCLES = 12;
  // receiver hold-off long enough to back up all pipeline stages
  localparam int unsigned LONG_HOLD_CYCLES = 300;

  // one write transaction toward the display driver
  typedef struct {
    logic [3:0] addr;
    logic [7:0] data;
    logic       last;
  } disp_wr_t;

  // keeps its own copy of the config and the writes still owed by the block
  class display_write_scoreboard;
    disp_wr_t   owed_writes_q[$];
    logic [7:0] decode_mode;
    logic [3:0] intensity;
    logic [2:0] scan_limit;
    int         errors;

    function new();
      decode_mode = 8'hFF;
      intensity   = 4'hF;
      scan_limit  = 3'd7;
      errors      = 0;
    endfunction

    function void set_cfg(logic [1:0] idx, logic [7:0] wdata);
      case (idx)
        CFG_DECODE: decode_mode = wdata;
        CFG_INTENS: intensity   = wdata[3:0];
        CFG_SCAN:   scan_limit  = wdata[2:0];
        default: ;
      endcase
    endfunction

    function void owe(logic [3:0] addr, logic [7:0] data, logic last);
      disp_wr_t w;
      w.addr = addr;
      w.data = data;
      w.last = last;
      owed_writes_q.push_back(w);
    endfunction

    // work out the burst of writes one accepted request causes
    function void format_request(logic [1:0] req, logic signed [15:0] temp, logic [7:0] hum);
      int          t;
      int unsigned v;
      logic [7:0]  d[5];
      logic [7:0]  hi, mid, lo;
      case (req)
        REQ_INIT: begin
          owe(ADDR_SHUTDOWN, SHUTDOWN_OFF, 1'b0);
          owe(ADDR_TEST, TEST_OFF, 1'b0);
          owe(ADDR_DECODE, decode_mode, 1'b0);
          owe(ADDR_INTENS, {4'h0, intensity}, 1'b0);
          owe(ADDR_SCAN, {5'h0, scan_limit}, 1'b1);
        end
        REQ_TEMP: begin
          t = temp;
          if (t > 9999) t = 9999;
          if (t < -9999) t = -9999;
          if (t < 0) begin
            d[0] = {4'h0, CODE_MINUS};
            v = -t;
          end else begin
            d[0] = {4'h0, CODE_BLANK};
            v = t;
          end
          d[4] = v % 10; v = v / 10;
          d[3] = v % 10; v = v / 10;
          d[2] = (v % 10) | DP_FLAG; v = v / 10;
          d[1] = v % 10;
          // a zero tens digit carries the sign instead
          if (d[1] == 8'h00) begin
            d[1] = d[0];
            d[0] = {4'h0, CODE_BLANK};
          end
          for (int i = 0; i < 5; i++) owe(ADDR_DIGIT0 + i, d[i], i == 4);
        end
        REQ_HUM: begin
          hi  = hum / 100;
          mid = (hum / 10) % 10;
          lo  = hum % 10;
          if (hi == 8'h00) begin
            hi = {4'h0, CODE_BLANK};
            if (mid == 8'h00) mid = {4'h0, CODE_BLANK};
          end
          owe(ADDR_DIGIT0 + 5, hi, 1'b0);
          owe(ADDR_DIGIT0 + 6, mid, 1'b0);
          owe(ADDR_DIGIT0 + 7, lo, 1'b1);
        end
        default: ;
      endcase
    endfunction

    function void check_write(logic [3:0] addr, logic [7:0] data, logic last);
      disp_wr_t w;
      if (owed_writes_q.size() == 0) begin
        $error("unexpected write: reg_addr %0h reg_data %0h last %0b", addr, data, last);
        errors++;
        return;
      end
      w = owed_writes_q.pop_front();
      if (addr !== w.addr) begin
        $error("reg_addr: expected %0h, actual %0h", w.addr, addr);
        errors++;
      end
      if (data !== w.data) begin
        $error("reg_data: expected %0h, actual %0h", w.data, data);
        errors++;
      end
      if (last !== w.last) begin
        $error("last: expected %0b, actual %0b", w.last, last);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         req_type;
  logic signed [15:0] temperature;
  logic [7:0]         humidity;
  logic               out_valid;
  logic               out_stall;
  logic [3:0]         reg_addr;
  logic [7:0]         reg_data;
  logic               last;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [7:0]         cfg_wdata;

  display_write_scoreboard sb;

  // idling controls shared by the sender, the receiver and the main sequence
  bit gap_en;
  bit stall_en;
  bit hold_req;

  seven_segment_value_formatter_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .req_type_i    (req_type),
    .temperature_i (temperature),
    .humidity_i    (humidity),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .reg_addr_o    (reg_addr),
    .reg_data_o    (reg_data),
    .last_o        (last),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit, far above the slowest legal run
  initial begin
    #5000000;
    $display("FAIL seven_segment_value_formatter_unit");
    $finish;
  end

  // receiver: random stall bursts, plus one long hold-off when requested
  // exactly one assignment to out_stall per clock edge
  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LONG_HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (stall_en && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor: every accepted write transaction is checked against the oldest owed one
  // values read here are the ones that held at the edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_write(reg_addr, reg_data, last);
  end

  // offer one request, with an optional idle burst first, and wait for its acceptance
  // valid stays high on return so back-to-back requests need no extra edge
  task automatic drive_req(input logic [1:0] req, input logic signed [15:0] temp,
                           input logic [7:0] hum);
    if (gap_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= req;
    temperature <= temp;
    humidity    <= hum;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.format_request(req, temp, hum);
  endtask

  // one config write transaction; valid stays high until the caller drops it
  task automatic write_cfg(input logic [1:0] idx, input logic [7:0] wdata);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= wdata;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_cfg(idx, wdata);
  endtask

  // all three registers, upper bits of intensity and scan limit filled with junk that the block must mask off
  task automatic apply_cfg(input logic [7:0] dec, input logic [3:0] inten,
                           input logic [2:0] scan);
    write_cfg(CFG_DECODE, dec);
    write_cfg(CFG_INTENS, {4'($urandom), inten});
    write_cfg(CFG_SCAN, {5'($urandom), scan});
    // stray write to the unmapped index, must change nothing
    write_cfg(CFG_NONE, 8'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // wait for every owed write, then let a dropped request drain out of the pipe
  task automatic wait_idle();
    while (sb.owed_writes_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // random requests until target ones that cause writes have been accepted
  task automatic run_random(input int target);
    int                 n_done;
    int unsigned        pick;
    logic [1:0]         req;
    logic signed [15:0] temp;
    n_done = 0;
    while (n_done < target) begin
      pick = $urandom_range(0, 19);
      if (pick < 2) req = REQ_INIT;
      else if (pick == 2) req = REQ_UNUSED;
      else if (pick < 12) req = REQ_TEMP;
      else req = REQ_HUM;
      case ($urandom_range(0, 3))
        0: temp = 16'($urandom);
        1: temp = 16'($urandom_range(0, 19998) - 9999);
        2: temp = 16'($urandom_range(0, 1998) - 999);
        default: begin
          // edges of saturation and of the digit boundaries
          case ($urandom_range(0, 7))
            0: temp = 16'sd9999;
            1: temp = -16'sd9999;
            2: temp = 16'sd10000 + 16'($urandom_range(0, 22767));
            3: temp = -16'sd10000 - 16'($urandom_range(0, 22768));
            4: temp = 16'($urandom_range(0, 99));
            5: temp = -16'($urandom_range(0, 99));
            6: temp = 16'($urandom_range(0, 9)) * 16'sd1000;
            default: temp = -16'($urandom_range(0, 9)) * 16'sd1000;
          endcase
        end
      endcase
      drive_req(req, temp, 8'($urandom));
      if (req != REQ_UNUSED) n_done++;
    end
    in_valid <= 1'b0;
  endtask

  // main sequence
  initial begin
    sb = new();
    gap_en   = 1'b1;
    stall_en = 1'b1;
    hold_req = 1'b0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    req_type    <= REQ_INIT;
    temperature <= '0;
    humidity    <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= CFG_DECODE;
    cfg_wdata   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part on the reset config
    drive_req(REQ_INIT, 16'sd0, 8'd0);
    drive_req(REQ_TEMP, 16'sd0, 8'd0);
    drive_req(REQ_TEMP, 16'sd1, 8'd0);
    drive_req(REQ_TEMP, -16'sd1, 8'd0);
    drive_req(REQ_TEMP, -16'sd5, 8'd0);      // tens zero on a negative value
    drive_req(REQ_TEMP, 16'sd999, 8'd0);
    drive_req(REQ_TEMP, -16'sd999, 8'd0);
    drive_req(REQ_TEMP, 16'sd1000, 8'd0);
    drive_req(REQ_TEMP, -16'sd1000, 8'd0);
    drive_req(REQ_TEMP, 16'sd1234, 8'd0);
    drive_req(REQ_TEMP, -16'sd4321, 8'd0);
    drive_req(REQ_TEMP, 16'sd9999, 8'd0);
    drive_req(REQ_TEMP, -16'sd9999, 8'd0);
    drive_req(REQ_TEMP, 16'sd10000, 8'd0);   // saturates high
    drive_req(REQ_TEMP, -16'sd10000, 8'd0);  // saturates low
    drive_req(REQ_TEMP, 16'sh7FFF, 8'hFF);
    drive_req(REQ_TEMP, 16'sh8000, 8'hFF);
    drive_req(REQ_HUM, 16'sh7FFF, 8'd0);     // both leading digits blanked
    drive_req(REQ_HUM, 16'sh8000, 8'd5);
    drive_req(REQ_HUM, 16'sd0, 8'd10);
    drive_req(REQ_HUM, 16'sd0, 8'd99);
    drive_req(REQ_HUM, 16'sd0, 8'd100);      // inner zero kept
    drive_req(REQ_HUM, 16'sd0, 8'd205);
    drive_req(REQ_HUM, 16'sd0, 8'd255);
    drive_req(REQ_UNUSED, 16'sh5555, 8'hAA); // dropped, no writes
    drive_req(REQ_UNUSED, -16'sh5556, 8'h55);
    in_valid <= 1'b0;
    wait_idle();

    // all registers at their low extreme
    apply_cfg(8'h00, 4'h0, 3'd0);
    run_random(70);
    wait_idle();

    // high extreme; long receiver hold-off while the sender keeps offering
    apply_cfg(8'hFF, 4'hF, 3'd7);
    gap_en   = 1'b0;
    hold_req = 1'b1;
    run_random(70);
    wait_idle();
    gap_en = 1'b1;

    // random settings
    repeat (3) begin
      apply_cfg(8'($urandom), 4'($urandom), 3'($urandom));
      run_random(70);
      wait_idle();
    end

    // closing stretch with no idling on either side
    gap_en   = 1'b0;
    stall_en = 1'b0;
    apply_cfg(8'($urandom), 4'($urandom), 3'($urandom));
    run_random(70);
    wait_idle();

    if (sb.owed_writes_q.size() != 0) begin
      $error("%0d owed writes never arrived", sb.owed_writes_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("PASS seven_segment_value_formatter_unit");
    end else begin
      $display("FAIL seven_segment_value_formatter_unit");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/ssvf_pkg.sv
src/ssvf_conv.sv
src/ssvf_fmt.sv
src/ssvf_ser.sv
src/seven_segment_value_formatter_unit.sv
dv/testbench.sv
